// ===== sv/tcbc_pkg.sv =====
// Shared types and constants for the TEA chained block cipher.
// Used by the register file, the round sequencer and the top level.
package tcbc_pkg;

    localparam int WORD_W   = 32;
    localparam int BLOCK_W  = 64;
    localparam int ROUND_W  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int KEY_WORDS = 4;

    localparam logic [WORD_W-1:0]  DELTA_RESET  = 32'h9E37_79B9;
    localparam logic [ROUND_W-1:0] ROUNDS_RESET = 7'd16;

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_DELTA  = 3'd4,
        REG_ROUNDS = 3'd5
    } cfg_idx_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [KEY_WORDS-1:0][WORD_W-1:0] key;
        logic [WORD_W-1:0]                delta;
        logic [ROUND_W-1:0]               rounds;
    } cfg_t;

endpackage

// ===== sv/tea_chained_block_cipher.sv =====
// TEA block cipher with double-XOR chaining, top level.
// Depends on tcbc_pkg, tcbc_cfg_regs and tcbc_core.
//
// Usage:
//   Input stream s_*: one 64-bit block per item in s_tdata, s_tuser[0] selects
//   encrypt (0) or decrypt (1), s_tuser[1] clears both chaining registers
//   before this block. Output stream m_*: the resulting block in m_tdata.
//   Configuration: cfg_wr_en/cfg_index/cfg_data write key words 0..3 (index
//   0..3), round delta (4) and round count (5); write only while idle.
// Operation:
//   With n = min(round_count, MAX_ROUNDS), an accepted item runs n TEA rounds
//   in the half-round unit (none for n = 0); the result is then registered
//   and m_tvalid rises. The unit does half a TEA cycle per clock. A new item
//   is taken only after the receiver has taken the result.
//   s_tready is high only while no item is in flight.
// Reset and stall:
//   Reset clears the chaining registers and loads the default configuration
//   (zero key, delta 0x9E3779B9, 16 rounds). When the receiver stalls, the
//   result is held in the output register and no new item is taken.
module tea_chained_block_cipher
    import tcbc_pkg::*;
#(
    parameter int MAX_ROUNDS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BLOCK_W-1:0]   s_tdata,   // [63:0] block_in
    input  logic [1:0]           s_tuser,   // [0] req_type, [1] first_block
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BLOCK_W-1:0]   m_tdata    // [63:0] block_out
);

    cfg_t cfg;

    tcbc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcbc_core #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_decrypt (s_tuser[0]),
        .in_first   (s_tuser[1]),
        .in_block   (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_block  (m_tdata)
    );

endmodule

// ===== sv/tcbc_cfg_regs.sv =====
// Configuration register file: key words, round delta and round count.
// Depends on tcbc_pkg.
module tcbc_cfg_regs
    import tcbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Write decode; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key    <= '0;
            cfg_reg.delta  <= DELTA_RESET;
            cfg_reg.rounds <= ROUNDS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_KEY0:   cfg_reg.key[0] <= cfg_data;
                REG_KEY1:   cfg_reg.key[1] <= cfg_data;
                REG_KEY2:   cfg_reg.key[2] <= cfg_data;
                REG_KEY3:   cfg_reg.key[3] <= cfg_data;
                REG_DELTA:  cfg_reg.delta  <= cfg_data;
                REG_ROUNDS: cfg_reg.rounds <= cfg_data[ROUND_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/tcbc_half_round.sv =====
// Shared TEA half-round unit: target +/- mix(other, ka, kb, sum).
// Depends on tcbc_pkg.
module tcbc_half_round
    import tcbc_pkg::*;
(
    input  logic [WORD_W-1:0] target,
    input  logic [WORD_W-1:0] other,
    input  logic [WORD_W-1:0] ka,
    input  logic [WORD_W-1:0] kb,
    input  logic [WORD_W-1:0] sum,
    input  logic              sub,
    output logic [WORD_W-1:0] result
);

    logic [WORD_W-1:0] mix;

    // ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb)
    assign mix = ((other << 4) + ka) ^ (other + sum) ^ ((other >> 5) + kb);

    assign result = sub ? (target - mix) : (target + mix);

endmodule

// ===== sv/tcbc_core.sv =====
// Round sequencer: chaining registers, TEA state and output register.
// Drives one tcbc_half_round unit per cycle. Depends on tcbc_pkg.
module tcbc_core
    import tcbc_pkg::*;
#(
    parameter int MAX_ROUNDS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_decrypt,
    input  logic               in_first,
    input  logic [BLOCK_W-1:0] in_block,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BLOCK_W-1:0] out_block
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0]  cc_reg, cc_next;     // previous ciphertext
    logic [BLOCK_W-1:0]  ci_reg, ci_next;     // previous raw TEA input/output
    logic [BLOCK_W-1:0]  out_reg, out_next;
    logic [BLOCK_W-1:0]  tin_reg, tin_next;   // TEA input of this item
    logic [WORD_W-1:0]   y_reg, y_next;
    logic [WORD_W-1:0]   z_reg, z_next;
    logic [WORD_W-1:0]   sum_reg, sum_next;
    logic [ROUND_W-1:0]  cnt_reg, cnt_next;
    logic                half_reg, half_next;
    logic                dec_reg, dec_next;

    logic [ROUND_W-1:0]  n_eff;
    logic [WORD_W-1:0]   sum_init;
    logic [BLOCK_W-1:0]  cc_in, ci_in, tea_in, tea_out, result;
    logic                upd_y;
    logic [WORD_W-1:0]   hr_target, hr_other, hr_ka, hr_kb, hr_result;
    logic                accept;

    // Round count saturates at MAX_ROUNDS
    assign n_eff = (32'(cfg.rounds) > MAX_ROUNDS) ? ROUND_W'(MAX_ROUNDS) : cfg.rounds;

    // Decrypt starts from delta * n_eff (the saturated round count)
    assign sum_init = in_decrypt ? WORD_W'(cfg.delta * WORD_W'(n_eff)) : cfg.delta;

    // Chaining values seen by a new item
    assign cc_in  = in_first ? '0 : cc_reg;
    assign ci_in  = in_first ? '0 : ci_reg;
    assign tea_in = in_decrypt ? (in_block ^ ci_in) : (in_block ^ cc_in);

    // Half-round routing: encrypt updates y then z, decrypt z then y
    assign upd_y     = (half_reg == dec_reg);
    assign hr_target = upd_y ? y_reg : z_reg;
    assign hr_other  = upd_y ? z_reg : y_reg;
    assign hr_ka     = upd_y ? cfg.key[0] : cfg.key[2];
    assign hr_kb     = upd_y ? cfg.key[1] : cfg.key[3];

    tcbc_half_round u_half_round (
        .target (hr_target),
        .other  (hr_other),
        .ka     (hr_ka),
        .kb     (hr_kb),
        .sum    (sum_reg),
        .sub    (dec_reg),
        .result (hr_result)
    );

    assign tea_out = {y_reg, z_reg};
    assign result  = dec_reg ? (tea_out ^ cc_reg) : (tea_out ^ ci_reg);
    assign accept  = in_valid && (state_reg == ST_IDLE);

    // Next-state and datapath
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cc_next        = cc_reg;
        ci_next        = ci_reg;
        out_next       = out_reg;
        tin_next       = tin_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        half_next      = half_reg;
        dec_next       = dec_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cc_next   = cc_in;
                    ci_next   = ci_in;
                    tin_next  = tea_in;
                    y_next    = tea_in[BLOCK_W-1:WORD_W];
                    z_next    = tea_in[WORD_W-1:0];
                    sum_next  = sum_init;
                    cnt_next  = n_eff;
                    half_next = 1'b0;
                    dec_next  = in_decrypt;
                    state_next = (n_eff == '0) ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (upd_y)
                    y_next = hr_result;
                else
                    z_next = hr_result;
                half_next = ~half_reg;
                if (half_reg)
                begin
                    sum_next = dec_reg ? (sum_reg - cfg.delta) : (sum_reg + cfg.delta);
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == ROUND_W'(1))
                        state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                out_next       = result;
                out_valid_next = 1'b1;
                if (dec_reg)
                begin
                    ci_next = tea_out;
                    cc_next = tin_reg ^ ci_reg;   // recovers the received block
                end
                else
                begin
                    ci_next = tin_reg;
                    cc_next = result;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and chaining registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cc_reg        <= '0;
            ci_reg        <= '0;
            cnt_reg       <= '0;
            half_reg      <= 1'b0;
            dec_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cc_reg        <= cc_next;
            ci_reg        <= ci_next;
            cnt_reg       <= cnt_next;
            half_reg      <= half_next;
            dec_reg       <= dec_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        tin_reg <= tin_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        sum_reg <= sum_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_block = out_reg;

endmodule

// ===== sv/tcbc_checker.sv =====
// Port-level checks for tea_chained_block_cipher, attached by bind.
// Depends on tcbc_pkg for widths.
module tcbc_checker
    import tcbc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [BLOCK_W-1:0] m_tdata
);

    // Only one item in flight: never ready while a result is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // Busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("not busy after accept");

    // Back to idle once the result is taken
    a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
        else $error("not idle after result taken");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind tea_chained_block_cipher tcbc_checker u_tcbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tea_chained_block_cipher_tb.sv =====
// Self-checking testbench for the TEA chained block cipher top level.
// Drives blocks and register writes, predicts every output block locally.
// Depends on tcbc_pkg and tea_chained_block_cipher.
`timescale 1ns / 1ps

module tea_chained_block_cipher_tb;
    import tcbc_pkg::*;

    localparam int MAX_ROUNDS     = 64;
    localparam int IDLE_PCT       = 36;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 2 * MAX_ROUNDS + 8;
    localparam int PHASE_ITEMS    = 80;
    localparam int PHASE_COUNT    = 8;

    // request kinds carried in s_tuser[0]
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // register indexes outside the map
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BLOCK_W-1:0]   s_tdata   = '0;   // [63:0] block_in
    logic [1:0]           s_tuser   = '0;   // [0] req_type, [1] first_block
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [BLOCK_W-1:0]   m_tdata;          // [63:0] block_out

    tea_chained_block_cipher #(.MAX_ROUNDS(MAX_ROUNDS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // local copy of configuration and chaining state
    logic [WORD_W-1:0]  key_copy [KEY_WORDS] = '{default: '0};
    logic [WORD_W-1:0]  delta_copy  = DELTA_RESET;
    logic [ROUND_W-1:0] rounds_copy = ROUNDS_RESET;
    logic [BLOCK_W-1:0] prev_cipher = '0;
    logic [BLOCK_W-1:0] prev_input  = '0;

    logic [BLOCK_W-1:0] expected_blocks [$];
    int                 error_count  = 0;
    int                 stall_cycles = 0;
    bit                 steady       = 1'b0;   // no idling on either side

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] v,
                                                  input logic [WORD_W-1:0] ka,
                                                  input logic [WORD_W-1:0] kb,
                                                  input logic [WORD_W-1:0] s);
        return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
    endfunction

    // round count saturates at MAX_ROUNDS
    function automatic int active_rounds();
        return (int'(rounds_copy) > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_copy);
    endfunction

    function automatic logic [BLOCK_W-1:0] tea_encipher(input logic [BLOCK_W-1:0] blk);
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] s;
        y = blk[63:32];
        z = blk[31:0];
        s = delta_copy;
        for (int i = 0; i < active_rounds(); i++)
        begin
            y = y + tea_mix(z, key_copy[0], key_copy[1], s);
            z = z + tea_mix(y, key_copy[2], key_copy[3], s);
            s = s + delta_copy;
        end
        return {y, z};
    endfunction

    function automatic logic [BLOCK_W-1:0] tea_decipher(input logic [BLOCK_W-1:0] blk);
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] s;
        y = blk[63:32];
        z = blk[31:0];
        s = delta_copy * WORD_W'(active_rounds());
        for (int i = 0; i < active_rounds(); i++)
        begin
            z = z - tea_mix(y, key_copy[2], key_copy[3], s);
            y = y - tea_mix(z, key_copy[0], key_copy[1], s);
            s = s - delta_copy;
        end
        return {y, z};
    endfunction

    // output block for one request; advances the chaining registers
    function automatic logic [BLOCK_W-1:0] chain_block(input logic req,
                                                       input logic first,
                                                       input logic [BLOCK_W-1:0] blk);
        logic [BLOCK_W-1:0] core_in;
        logic [BLOCK_W-1:0] result;
        if (first)
        begin
            prev_cipher = '0;
            prev_input  = '0;
        end
        if (req == OP_ENCRYPT)
        begin
            core_in     = blk ^ prev_cipher;
            result      = tea_encipher(core_in) ^ prev_input;
            prev_input  = core_in;
            prev_cipher = result;
        end
        else
        begin
            core_in     = tea_decipher(blk ^ prev_input);
            result      = core_in ^ prev_cipher;
            prev_input  = core_in;
            prev_cipher = blk;
        end
        return result;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // one register write; the local copy follows it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_KEY0:   key_copy[0] = data;
            REG_KEY1:   key_copy[1] = data;
            REG_KEY2:   key_copy[2] = data;
            REG_KEY3:   key_copy[3] = data;
            REG_DELTA:  delta_copy  = data;
            REG_ROUNDS: rounds_copy = data[ROUND_W-1:0];
            default:    ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // send one block item, queue its predicted output
    task automatic send_block(input logic req, input logic first,
                              input logic [BLOCK_W-1:0] blk,
                              output logic [BLOCK_W-1:0] predicted);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        s_tuser  <= {first, req};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = chain_block(req, first, blk);
        expected_blocks.push_back(predicted);
    endtask

    // block idle: all outputs back, nothing in flight
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word(input logic [WORD_W-1:0] typical);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return typical;
        return $urandom;
    endfunction

    // ---------------------------------------------------------------
    // Receiver and checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [BLOCK_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_blocks.size() == 0)
                report_mismatch($sformatf("unexpected block_out %h", m_tdata));
            else
            begin
                want = expected_blocks.pop_front();
                if (m_tdata !== want)
                    report_mismatch($sformatf("block_out %h, expected %h", m_tdata, want));
            end
        end
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // reset configuration, encrypt and decrypt chains
    task automatic test_reset_defaults();
        logic [BLOCK_W-1:0] out_blk;
        send_block(OP_ENCRYPT, 1'b1, '0, out_blk);
        send_block(OP_ENCRYPT, 1'b0, '1, out_blk);
        send_block(OP_ENCRYPT, 1'b0, {$urandom, $urandom}, out_blk);
        send_block(OP_DECRYPT, 1'b1, '1, out_blk);
        send_block(OP_DECRYPT, 1'b0, '0, out_blk);
        wait_until_idle();
    endtask

    // one round, zero rounds (pass-through core), full and saturated counts
    task automatic test_round_limits();
        logic [BLOCK_W-1:0] out_blk;
        logic [ROUND_W-1:0] counts [5] = '{7'd1, 7'd0, 7'd64, 7'd65, 7'd127};
        foreach (counts[i])
        begin
            write_reg(REG_ROUNDS, {$urandom_range(0, 1) ? 25'h1FF_FFFF : 25'h0, counts[i]});
            send_block(OP_ENCRYPT, 1'b1, {$urandom, $urandom}, out_blk);
            send_block(OP_DECRYPT, 1'b0, {$urandom, $urandom}, out_blk);
            wait_until_idle();
        end
    endtask

    // all-ones key and delta, then zero key words 0 and 3 and zero delta
    task automatic test_key_delta_extremes();
        logic [BLOCK_W-1:0] out_blk;
        write_reg(REG_KEY0, '1);
        write_reg(REG_KEY1, '1);
        write_reg(REG_KEY2, '1);
        write_reg(REG_KEY3, '1);
        write_reg(REG_DELTA, '1);
        write_reg(REG_ROUNDS, 32'd8);
        send_block(OP_ENCRYPT, 1'b1, '1, out_blk);
        send_block(OP_DECRYPT, 1'b0, '0, out_blk);
        wait_until_idle();
        write_reg(REG_KEY0, '0);
        write_reg(REG_KEY3, '0);
        write_reg(REG_DELTA, '0);
        send_block(OP_DECRYPT, 1'b1, '1, out_blk);
        send_block(OP_ENCRYPT, 1'b0, '0, out_blk);
        wait_until_idle();
    endtask

    // writes to indexes outside the map must change nothing
    task automatic test_unknown_index();
        logic [BLOCK_W-1:0] out_blk;
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        send_block(OP_ENCRYPT, 1'b1, {$urandom, $urandom}, out_blk);
        send_block(OP_ENCRYPT, 1'b0, {$urandom, $urandom}, out_blk);
        wait_until_idle();
    endtask

    // random configuration per phase; mostly messages with round trips
    task automatic test_random_traffic();
        logic [BLOCK_W-1:0] cipher_blocks [6];
        logic [BLOCK_W-1:0] out_blk;
        logic [ROUND_W-1:0] rounds;
        logic               req;
        int                 sent;
        int                 kind;
        int                 len;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_until_idle();
            steady = (phase == 3);
            kind = $urandom_range(0, 9);
            if (kind < 7)
                rounds = ROUND_W'($urandom_range(1, 6));
            else if (kind == 7)
                rounds = 7'd0;
            else if (kind == 8)
                rounds = 7'd64;
            else
                rounds = ROUND_W'($urandom_range(16, 127));
            write_reg(REG_KEY0, pick_word('0));
            write_reg(REG_KEY1, pick_word('0));
            write_reg(REG_KEY2, pick_word('0));
            write_reg(REG_KEY3, pick_word('0));
            write_reg(REG_DELTA, pick_word(DELTA_RESET));
            write_reg(REG_ROUNDS, {25'($urandom), rounds});
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                kind = $urandom_range(0, 9);
                len  = $urandom_range(1, 6);
                if (kind < 6)
                begin
                    // encrypt a message, then decrypt its ciphertext
                    for (int i = 0; i < len; i++)
                    begin
                        send_block(OP_ENCRYPT, i == 0, {$urandom, $urandom}, out_blk);
                        cipher_blocks[i] = out_blk;
                    end
                    for (int i = 0; i < len; i++)
                        send_block(OP_DECRYPT, i == 0, cipher_blocks[i], out_blk);
                    sent += 2 * len;
                end
                else if (kind < 8)
                begin
                    // one chained message of a single kind
                    req = 1'($urandom_range(0, 1));
                    for (int i = 0; i < len; i++)
                        send_block(req, i == 0, {$urandom, $urandom}, out_blk);
                    sent += len;
                end
                else
                begin
                    // noise: any kind, any chaining flag
                    send_block(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               {$urandom, $urandom}, out_blk);
                    sent++;
                end
            end
            steady = 1'b0;
        end
        wait_until_idle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_round_limits();
        test_key_delta_extremes();
        test_unknown_index();
        test_random_traffic();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_blocks.size() != 0)
            report_mismatch($sformatf("%0d output blocks never arrived",
                                      expected_blocks.size()));
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tcbc_pkg.sv
sv/tcbc_cfg_regs.sv
sv/tcbc_half_round.sv
sv/tcbc_core.sv
sv/tea_chained_block_cipher.sv
sv/tcbc_checker.sv
tb/tea_chained_block_cipher_tb.sv
